FILE: rtl/core/bh256_pkg.sv
// Shared types, constants and helper functions of the 256-bit block hash engine.
// Used by bh256_chain and block_hash_256_engine; depends on nothing else.

package bh256_pkg;

	// Number of mixing rounds per block; the round constant table holds up to twelve.
	localparam int ROUNDS = 12;

	// Block geometry: eight 64-bit words, addressed by three bits.
	localparam int WORD_W = 64;
	localparam int BLK_WORDS = 8;
	localparam int WADDR_W = $clog2(BLK_WORDS);

	// Whitening constant applied before the two closing permutations.
	localparam logic [WORD_W-1:0] WHITEN = 64'h0123456789ABCDEF;

	// Operations that the chaining datapath performs.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_XOR_W,
		OP_STEP_A,
		OP_STEP_B,
		OP_STEP_C,
		OP_STEP_D,
		OP_MERGE,
		OP_WHITEN,
		OP_LOAD_IV
	} op_t;

	// Control group handed from the sequencer to the chaining datapath.
	typedef struct packed {
		op_t        op;
		logic [3:0] rnd;
		logic [1:0] sel;
	} chain_ctrl_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ABSORB,
		ST_MIX,
		ST_WHITEN,
		ST_EMIT
	} state_t;

	// What the current permutation is working on, and so what follows it.
	typedef enum logic [2:0] {
		JOB_DATA,
		JOB_PAD_OVF,
		JOB_PAD_LAST,
		JOB_ZERO1,
		JOB_ZERO2
	} job_t;

	// Per-round constants.
	function automatic logic [WORD_W-1:0] rc_of(input logic [3:0] r);
		case (r)
			4'd0:    rc_of = 64'h243F6A8885A308D3;
			4'd1:    rc_of = 64'h13198A2E03707344;
			4'd2:    rc_of = 64'hA4093822299F31D0;
			4'd3:    rc_of = 64'h082EFA98EC4E6C89;
			4'd4:    rc_of = 64'h452821E638D01377;
			4'd5:    rc_of = 64'hBE5466CF34E90C6C;
			4'd6:    rc_of = 64'hC0AC29B7C97C50DD;
			4'd7:    rc_of = 64'h3F84D5B5B5470917;
			4'd8:    rc_of = 64'h9216D5D98979FB1B;
			4'd9:    rc_of = 64'hD1310BA698DFB5AC;
			4'd10:   rc_of = 64'h2FFD72DBD01ADFB7;
			4'd11:   rc_of = 64'hB8E1AFED6A267E96;
			default: rc_of = '0;
		endcase
	endfunction

	// Initial chaining values.
	function automatic logic [WORD_W-1:0] iv_of(input logic [1:0] i);
		case (i)
			2'd0:    iv_of = 64'h6A09E667F3BCC908;
			2'd1:    iv_of = 64'hBB67AE8584CAA73B;
			2'd2:    iv_of = 64'h3C6EF372FE94F82B;
			default: iv_of = 64'hA54FF53A5F1D36F1;
		endcase
	endfunction

	// Rotate left by 0 to 63 places.
	function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
			input logic [5:0] n);
		logic [2*WORD_W-1:0] t;
		t = {x, x} << n;
		rotl = t[2*WORD_W-1:WORD_W];
	endfunction

endpackage

FILE: rtl/core/bh256_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Stands alone; holds the message block of the hash engine.

module bh256_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/bh256_chain.sv
// Chaining state of the hash engine and the one-step-per-cycle round datapath.
// Depends on bh256_pkg for the operation codes, constants and rotate helper.

module bh256_chain (
	input  logic                            clk,
	input  logic                            arst_n,
	input  bh256_pkg::chain_ctrl_t          ctrl,
	input  logic [bh256_pkg::WORD_W-1:0]    word,
	input  logic [1:0]                      rd_sel,
	output logic [bh256_pkg::WORD_W-1:0]    rd_word
);

	logic [bh256_pkg::WORD_W-1:0] st_q [4];
	logic [bh256_pkg::WORD_W-1:0] st_d [4];
	logic [bh256_pkg::WORD_W-1:0] rc;
	logic [bh256_pkg::WORD_W-1:0] m1;
	logic [bh256_pkg::WORD_W-1:0] m3;
	logic [5:0]                   rnd6;

	assign rc      = bh256_pkg::rc_of(ctrl.rnd);
	assign rnd6    = {2'b00, ctrl.rnd};
	assign rd_word = st_q[rd_sel];
	assign m1      = st_q[1] ^ st_q[2];
	assign m3      = st_q[3] ^ st_q[0];

	// One step of the round, or an absorb, whitening or reload step.
	always_comb begin
		st_d = st_q;
		case (ctrl.op)
			bh256_pkg::OP_XOR_W: begin
				st_d[ctrl.sel] = st_q[ctrl.sel] ^ word;
			end
			bh256_pkg::OP_STEP_A: begin
				st_d[0] = bh256_pkg::rotl((st_q[0] ^ rc) + (word ^ st_q[1] ^ rc),
					6'd7 + rnd6);
				st_d[1] = st_q[1] ^ rc;
				st_d[2] = st_q[2] ^ rc;
				st_d[3] = st_q[3] ^ rc;
			end
			bh256_pkg::OP_STEP_B: begin
				st_d[1] = bh256_pkg::rotl(st_q[1] ^ (st_q[2] + word), 6'd13 + rnd6);
			end
			bh256_pkg::OP_STEP_C: begin
				st_d[2] = bh256_pkg::rotl(st_q[2] + (st_q[3] ^ word), 6'd17 + rnd6);
			end
			bh256_pkg::OP_STEP_D: begin
				st_d[3] = bh256_pkg::rotl(st_q[3] ^ (st_q[0] + word), 6'd23 + rnd6);
			end
			bh256_pkg::OP_MERGE: begin
				st_d[0] = (st_q[0] + st_q[1]) ^ bh256_pkg::rotl(m1, 6'd11);
				st_d[1] = m1;
				st_d[2] = (st_q[2] + st_q[3]) ^ bh256_pkg::rotl(m3, 6'd19);
				st_d[3] = m3;
			end
			bh256_pkg::OP_WHITEN: begin
				// Word three sees the already whitened word zero.
				st_d[0] = st_q[0] ^ bh256_pkg::WHITEN ^ st_q[1];
				st_d[1] = st_q[1] ^ bh256_pkg::WHITEN ^ st_q[2];
				st_d[2] = st_q[2] ^ bh256_pkg::WHITEN ^ st_q[3];
				st_d[3] = st_q[3] ^ bh256_pkg::WHITEN ^ st_d[0];
			end
			bh256_pkg::OP_LOAD_IV: begin
				for (int i = 0; i < 4; i++) begin
					st_d[i] = bh256_pkg::iv_of(2'(i));
				end
			end
			default: begin
				st_d = st_q;
			end
		endcase
	end

	// Chaining state registers, loaded with the initial values at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				st_q[i] <= bh256_pkg::iv_of(2'(i));
			end
		end else begin
			st_q <= st_d;
		end
	end

endmodule

FILE: rtl/core/block_hash_256_engine.sv
// Top level of the byte-serial 256-bit block hash engine: input handshake, word packing,
// sequencer, block RAM and chaining datapath. Depends on bh256_pkg, bh256_ram, bh256_chain.
//
// Usage. An item (data_byte, has_byte, end_of_message) is taken at a rising edge where
// start is high and busy is low. Bytes are packed into big-endian 64-bit words and written
// into an eight-word block RAM. An item with has_byte low and end_of_message low does nothing.
// Throughput: one item per cycle while busy is low; the item carrying the 64th byte of a
// block raises busy while the block is absorbed: four words are XORed in, then each round
// runs five steps, one per cycle, four add-rotate steps and a merge, since the round reads
// four block words through the single RAM read port and chains its adds.
// End of message: padding writes the remaining words of the block (one per cycle), the
// padded block is absorbed (a second one when the 0x80 byte lands at offset 48 or later),
// one whitening step follows, then two zero-block permutations.
// After that the four digest words appear on consecutive cycles, word_index 0 first, each
// for one cycle with strobe high; last_word marks the fourth. The receiver cannot stall.
// busy stays high until the last word has gone; the chain and byte count then return to
// their initial values. Reset (arst_n low) loads the initial chaining values and clears
// the byte count and the sequencer; the block RAM needs no clearing.

module block_hash_256_engine #(
	parameter int ROUNDS = bh256_pkg::ROUNDS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [7:0]                   data_byte,
	input  logic                         has_byte,
	input  logic                         end_of_message,
	output logic                         strobe,
	output logic [bh256_pkg::WORD_W-1:0] digest_word,
	output logic [1:0]                   word_index,
	output logic                         last_word
);

	localparam logic [bh256_pkg::WADDR_W-1:0] LAST_WORD =
		bh256_pkg::WADDR_W'(bh256_pkg::BLK_WORDS - 1);
	localparam logic [3:0] LAST_RND = 4'(ROUNDS - 1);

	bh256_pkg::state_t state_q, state_d;
	bh256_pkg::job_t   job_q, job_d;
	logic [2:0]        ph_q, ph_d;
	logic [3:0]        rnd_q, rnd_d;
	logic [bh256_pkg::WADDR_W-1:0] wp_q, wp_d;
	logic              second_q, second_d;
	logic              end_pend_q, end_pend_d;
	logic [63:0]       count_q, count_d;
	logic [63:0]       acc_q, acc_d;

	logic                             accept;
	logic [63:0]                      count_inc;
	logic [63:0]                      packed_word;
	logic [63:0]                      pad_word;
	logic [63:0]                      len_word;
	logic [2:0]                       rnd3;
	logic                             ram_we;
	logic [bh256_pkg::WADDR_W-1:0]    ram_waddr;
	logic [63:0]                      ram_wdata;
	logic [bh256_pkg::WADDR_W-1:0]    ram_raddr;
	logic [63:0]                      ram_rdata;
	logic [63:0]                      mix_word;
	bh256_pkg::chain_ctrl_t           ctrl;

	assign accept      = start && !busy;
	assign busy        = (state_q != bh256_pkg::ST_IDLE);
	assign count_inc   = count_q + 64'd1;
	assign packed_word = {acc_q[55:0], data_byte};
	assign len_word    = {count_q[60:0], 3'b000};
	assign rnd3        = rnd_q[2:0];

	// Final partial word: the collected bytes left-aligned, then 0x80, then zeros.
	assign pad_word = {acc_q[55:0], 8'h80} << {3'd7 - count_q[2:0], 3'b000};

	// Zero-block permutations see an all-zero message.
	assign mix_word = (job_q == bh256_pkg::JOB_ZERO1 || job_q == bh256_pkg::JOB_ZERO2)
		? '0 : ram_rdata;

	// Result port: a digest word straight from the chaining registers.
	assign strobe     = (state_q == bh256_pkg::ST_EMIT);
	assign word_index = ph_q[1:0];
	assign last_word  = strobe && (ph_q[1:0] == 2'd3);

	// Sequencer: next state, RAM addressing and datapath step.
	always_comb begin
		state_d    = state_q;
		job_d      = job_q;
		ph_d       = ph_q;
		rnd_d      = rnd_q;
		wp_d       = wp_q;
		second_d   = second_q;
		end_pend_d = end_pend_q;
		count_d    = count_q;
		acc_d      = acc_q;
		ram_we     = 1'b0;
		ram_waddr  = count_q[5:3];
		ram_wdata  = packed_word;
		ram_raddr  = '0;
		ctrl.op    = bh256_pkg::OP_NONE;
		ctrl.rnd   = rnd_q;
		ctrl.sel   = 2'd0;
		case (state_q)
			bh256_pkg::ST_IDLE: begin
				if (accept) begin
					if (has_byte) begin
						acc_d   = packed_word;
						count_d = count_inc;
						// A full word goes into the block RAM.
						if (count_inc[2:0] == 3'd0) begin
							ram_we = 1'b1;
						end
					end
					if (has_byte && count_inc[5:0] == 6'd0) begin
						state_d    = bh256_pkg::ST_ABSORB;
						job_d      = bh256_pkg::JOB_DATA;
						ph_d       = 3'd0;
						end_pend_d = end_of_message;
					end else if (end_of_message) begin
						state_d  = bh256_pkg::ST_PAD;
						second_d = 1'b0;
						wp_d     = count_d[5:3];
					end
				end
			end
			bh256_pkg::ST_PAD: begin
				// One padding word per cycle up to the end of the block.
				ram_we    = 1'b1;
				ram_waddr = wp_q;
				if (!second_q && wp_q == count_q[5:3]) begin
					ram_wdata = pad_word;
				end else if (wp_q == LAST_WORD && (second_q || count_q[5:4] != 2'b11)) begin
					ram_wdata = len_word;
				end else begin
					ram_wdata = '0;
				end
				if (wp_q == LAST_WORD) begin
					state_d = bh256_pkg::ST_ABSORB;
					ph_d    = 3'd0;
					if (!second_q && count_q[5:4] == 2'b11) begin
						job_d = bh256_pkg::JOB_PAD_OVF;
					end else begin
						job_d = bh256_pkg::JOB_PAD_LAST;
					end
				end else begin
					wp_d = wp_q + bh256_pkg::WADDR_W'(1);
				end
			end
			bh256_pkg::ST_ABSORB: begin
				// Read word ph, XOR in word ph-1 that the RAM returns now.
				ram_raddr = (ph_q < 3'd4) ? ph_q : '0;
				if (ph_q != 3'd0) begin
					ctrl.op  = bh256_pkg::OP_XOR_W;
					ctrl.sel = 2'(ph_q - 3'd1);
				end
				if (ph_q == 3'd4) begin
					state_d = bh256_pkg::ST_MIX;
					ph_d    = 3'd0;
					rnd_d   = 4'd0;
				end else begin
					ph_d = ph_q + 3'd1;
				end
			end
			bh256_pkg::ST_MIX: begin
				// Five steps per round; each read is issued in the cycle before the step that uses it.
				case (ph_q)
					3'd0: begin
						ctrl.op   = bh256_pkg::OP_STEP_A;
						ram_raddr = rnd3 + 3'd1;
					end
					3'd1: begin
						ctrl.op   = bh256_pkg::OP_STEP_B;
						ram_raddr = rnd3 + 3'd2;
					end
					3'd2: begin
						ctrl.op   = bh256_pkg::OP_STEP_C;
						ram_raddr = rnd3 + 3'd3;
					end
					3'd3: begin
						ctrl.op = bh256_pkg::OP_STEP_D;
					end
					default: begin
						ctrl.op   = bh256_pkg::OP_MERGE;
						ram_raddr = rnd3 + 3'd1;
					end
				endcase
				if (ph_q == 3'd4) begin
					ph_d = 3'd0;
					if (rnd_q == LAST_RND) begin
						rnd_d = 4'd0;
						case (job_q)
							bh256_pkg::JOB_DATA: begin
								if (end_pend_q) begin
									state_d    = bh256_pkg::ST_PAD;
									second_d   = 1'b0;
									wp_d       = '0;
									end_pend_d = 1'b0;
								end else begin
									state_d = bh256_pkg::ST_IDLE;
								end
							end
							bh256_pkg::JOB_PAD_OVF: begin
								state_d  = bh256_pkg::ST_PAD;
								second_d = 1'b1;
								wp_d     = '0;
							end
							bh256_pkg::JOB_PAD_LAST: begin
								state_d = bh256_pkg::ST_WHITEN;
							end
							bh256_pkg::JOB_ZERO1: begin
								job_d = bh256_pkg::JOB_ZERO2;
							end
							default: begin
								state_d = bh256_pkg::ST_EMIT;
							end
						endcase
					end else begin
						rnd_d = rnd_q + 4'd1;
					end
				end else begin
					ph_d = ph_q + 3'd1;
				end
			end
			bh256_pkg::ST_WHITEN: begin
				ctrl.op = bh256_pkg::OP_WHITEN;
				state_d = bh256_pkg::ST_MIX;
				job_d   = bh256_pkg::JOB_ZERO1;
				ph_d    = 3'd0;
				rnd_d   = 4'd0;
			end
			bh256_pkg::ST_EMIT: begin
				// Four digest words, then re-arm for the next message.
				if (ph_q[1:0] == 2'd3) begin
					ctrl.op = bh256_pkg::OP_LOAD_IV;
					count_d = '0;
					ph_d    = 3'd0;
					state_d = bh256_pkg::ST_IDLE;
				end else begin
					ph_d = ph_q + 3'd1;
				end
			end
			default: begin
				state_d = bh256_pkg::ST_IDLE;
			end
		endcase
	end

	// Sequencer and counter registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= bh256_pkg::ST_IDLE;
			job_q      <= bh256_pkg::JOB_DATA;
			ph_q       <= '0;
			rnd_q      <= '0;
			wp_q       <= '0;
			second_q   <= 1'b0;
			end_pend_q <= 1'b0;
			count_q    <= '0;
		end else begin
			state_q    <= state_d;
			job_q      <= job_d;
			ph_q       <= ph_d;
			rnd_q      <= rnd_d;
			wp_q       <= wp_d;
			second_q   <= second_d;
			end_pend_q <= end_pend_d;
			count_q    <= count_d;
		end
	end

	// Byte collector; its stale upper bytes never reach the RAM.
	always_ff @(posedge clk) begin
		acc_q <= acc_d;
	end

	// Message block memory.
	bh256_ram #(
		.WIDTH (bh256_pkg::WORD_W),
		.DEPTH (bh256_pkg::BLK_WORDS)
	) u_block_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Chaining state and round datapath.
	bh256_chain u_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.word    (mix_word),
		.rd_sel  (ph_q[1:0]),
		.rd_word (digest_word)
	);

	// The digest words leave in order, one per cycle, without gaps.
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe && word_index != 2'd3 |=> strobe && word_index == $past(word_index) + 2'd1)
		else $error("digest words not emitted in order");

	// After the fourth word the engine is free for the next message.
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last_word |=> !strobe && !busy)
		else $error("engine not re-armed after the last digest word");

	// A completed block always starts an absorb on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && has_byte && count_inc[5:0] == 6'd0 |=> state_q == bh256_pkg::ST_ABSORB)
		else $error("full block not absorbed");

	// The byte count is back at zero whenever the digest has gone.
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last_word |=> count_q == 64'd0)
		else $error("byte count not cleared after digest");

endmodule

FILE: dv/tb_block_hash_256_engine.sv
// Self-checking testbench for block_hash_256_engine: drives byte items, predicts digests.
// Depends on bh256_pkg and the block_hash_256_engine RTL with bh256_ram and bh256_chain.
`timescale 1ns / 1ps

module tb_block_hash_256_engine;

	// One input item as it sits in the pending queue.
	typedef struct {
		logic [7:0] data;
		logic       has;
		logic       eom;
	} byte_item_t;

	// One digest word as the block should present it.
	typedef struct {
		logic [63:0] word;
		logic [1:0]  idx;
		logic        last;
	} digest_res_t;

	typedef logic [63:0] word_blk_t [8];

	localparam int QUIET_LIMIT = 2000;
	localparam int TAIL_CYCLES = 300;
	localparam logic [63:0] WHITE_K = 64'h0123456789ABCDEF;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [7:0]  data_byte = 8'h00;
	logic        has_byte = 1'b0;
	logic        end_of_message = 1'b0;
	logic        busy;
	logic        strobe;
	logic [bh256_pkg::WORD_W-1:0] digest_word;
	logic [1:0]  word_index;
	logic        last_word;

	// Predictor state: chaining words, current block bytes, message length in bytes.
	logic [63:0] hash_chain [4];
	logic [7:0]  msg_buf [64];
	logic [63:0] msg_len;

	logic [63:0] round_const [12] = '{
		64'h243F6A8885A308D3, 64'h13198A2E03707344, 64'hA4093822299F31D0,
		64'h082EFA98EC4E6C89, 64'h452821E638D01377, 64'hBE5466CF34E90C6C,
		64'hC0AC29B7C97C50DD, 64'h3F84D5B5B5470917, 64'h9216D5D98979FB1B,
		64'hD1310BA698DFB5AC, 64'h2FFD72DBD01ADFB7, 64'hB8E1AFED6A267E96
	};
	logic [63:0] chain_init [4] = '{
		64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B,
		64'h3C6EF372FE94F82B, 64'hA54FF53A5F1D36F1
	};

	byte_item_t  byte_q [$];
	digest_res_t digest_q [$];
	int          total_items = 0;
	int          sent_cnt = 0;
	int          mismatches = 0;
	int          quiet_cycles = 0;

	block_hash_256_engine i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.data_byte      (data_byte),
		.has_byte       (has_byte),
		.end_of_message (end_of_message),
		.strobe         (strobe),
		.digest_word    (digest_word),
		.word_index     (word_index),
		.last_word      (last_word)
	);

	// 8 ns clock.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [63:0] rol64(input logic [63:0] x, input int unsigned n);
		int unsigned k;
		k = n % 64;
		if (k == 0)
			return x;
		return (x << k) | (x >> (64 - k));
	endfunction

	// The round permutation over the chaining words, keyed by eight block words.
	function automatic void permute_block(input word_blk_t w);
		logic [63:0] a, b, c, d;
		for (int r = 0; r < bh256_pkg::ROUNDS && r < 12; r++) begin
			for (int i = 0; i < 4; i++)
				hash_chain[i] ^= round_const[r];
			a = hash_chain[0];
			b = hash_chain[1];
			c = hash_chain[2];
			d = hash_chain[3];
			a = rol64(a + (w[r % 8] ^ b), 7 + r);
			b = rol64(b ^ (c + w[(r + 1) % 8]), 13 + r);
			c = rol64(c + (d ^ w[(r + 2) % 8]), 17 + r);
			d = rol64(d ^ (a + w[(r + 3) % 8]), 23 + r);
			hash_chain[0] = a + b;
			hash_chain[1] = b ^ c;
			hash_chain[2] = c + d;
			hash_chain[3] = d ^ a;
			hash_chain[0] ^= rol64(hash_chain[1], 11);
			hash_chain[2] ^= rol64(hash_chain[3], 19);
		end
	endfunction

	// Packs the block bytes big-endian, folds the first four words in, then permutes.
	function automatic void absorb_block();
		word_blk_t w;
		for (int i = 0; i < 8; i++) begin
			w[i] = '0;
			for (int j = 0; j < 8; j++)
				w[i] = (w[i] << 8) | msg_buf[i * 8 + j];
		end
		for (int i = 0; i < 4; i++)
			hash_chain[i] ^= w[i];
		permute_block(w);
	endfunction

	function automatic void chain_restart();
		for (int i = 0; i < 4; i++)
			hash_chain[i] = chain_init[i];
		msg_len = '0;
	endfunction

	// Updates the predicted state for one accepted item and queues any digest it produces.
	function automatic void fold_item(input byte_item_t it);
		int          fill;
		logic [63:0] bit_len;
		word_blk_t   zb;
		digest_res_t res;
		if (it.has) begin
			msg_buf[msg_len[5:0]] = it.data;
			msg_len++;
			if (msg_len[5:0] == 6'd0)
				absorb_block();
		end
		if (!it.eom)
			return;
		// Padding: marker byte, zeros, then the bit length in the last eight bytes.
		fill = int'(msg_len[5:0]);
		msg_buf[fill] = 8'h80;
		for (int i = fill + 1; i < 64; i++)
			msg_buf[i] = 8'h00;
		if (fill >= 48) begin
			absorb_block();
			for (int i = 0; i < 64; i++)
				msg_buf[i] = 8'h00;
		end
		bit_len = msg_len << 3;
		for (int i = 0; i < 8; i++)
			msg_buf[56 + i] = bit_len[63 - 8 * i -: 8];
		absorb_block();
		// Whitening runs in place, so the last word sees the updated first word.
		for (int i = 0; i < 4; i++)
			hash_chain[i] ^= WHITE_K ^ hash_chain[(i + 1) % 4];
		zb = '{default: '0};
		permute_block(zb);
		permute_block(zb);
		for (int i = 0; i < 4; i++) begin
			res.word = hash_chain[i];
			res.idx = 2'(i);
			res.last = (i == 3);
			digest_q.insert(digest_q.size(), res);
		end
		chain_restart();
	endfunction

	function automatic void add_item(input logic [7:0] d, input logic h, input logic e);
		byte_item_t it;
		it.data = d;
		it.has = h;
		it.eom = e;
		byte_q.insert(byte_q.size(), it);
	endfunction

	// Queues a whole message: len random bytes with the odd ignored item in between,
	// ended either on the last byte or by a separate item without a byte.
	function automatic int add_message(input int len, input bit end_on_byte);
		int n;
		n = 0;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(15, 0) == 0)
				add_item(8'($urandom), 1'b0, 1'b0);
			add_item(8'($urandom), 1'b1, (i == len - 1) && end_on_byte);
			n++;
		end
		if (len == 0 || !end_on_byte) begin
			add_item(8'($urandom), 1'b0, 1'b1);
			n++;
		end
		return n;
	endfunction

	// Stimulus, then wait for the digests to drain, then the verdict.
	initial begin
		int useful;
		int msgs;
		int len;
		int pick;
		chain_restart();
		for (int i = 0; i < 64; i++)
			msg_buf[i] = 8'h00;

		// Directed: empty messages, ignored items, single-byte extremes, both endings.
		add_item(8'hA5, 1'b0, 1'b1);
		add_item(8'hFF, 1'b0, 1'b0);
		add_item(8'h00, 1'b1, 1'b1);
		add_item(8'hFF, 1'b1, 1'b0);
		add_item(8'h5A, 1'b0, 1'b1);
		add_item(8'h80, 1'b1, 1'b0);
		add_item(8'h00, 1'b0, 1'b0);
		add_item(8'h7F, 1'b1, 1'b0);
		add_item(8'h01, 1'b1, 1'b1);
		add_item(8'h00, 1'b0, 1'b1);
		add_item(8'hFF, 1'b0, 1'b1);
		useful = 9;
		msgs = 6;

		// Padding that spills into a second block, and an exactly full block.
		useful += add_message(56, 1'b1);
		useful += add_message(64, 1'b0);
		msgs += 2;

		// Random messages: mostly short, some around a block boundary, a few multi-block.
		while (useful < 230 || msgs < 12) begin
			pick = $urandom_range(99, 0);
			if (pick < 55)
				len = $urandom_range(12, 0);
			else if (pick < 90)
				len = $urandom_range(70, 44);
			else
				len = $urandom_range(135, 120);
			useful += add_message(len, $urandom_range(1, 0));
			msgs++;
		end
		total_items = byte_q.size();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (byte_q.size() != 0 || digest_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0 && digest_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Driver: presents the head of the queue, predicts on acceptance, idles by phase.
	always @(posedge clk) begin
		int idle_pct;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				fold_item(byte_q.pop_front());
				sent_cnt++;
			end
			if (sent_cnt < total_items / 3)
				idle_pct = 27;
			else if (sent_cnt < 2 * total_items / 3)
				idle_pct = 57;
			else
				idle_pct = 0;
			// An item already offered stays on the ports until it is taken.
			if (!(start && busy)) begin
				if (byte_q.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
					start <= 1'b1;
					data_byte <= byte_q[0].data;
					has_byte <= byte_q[0].has;
					end_of_message <= byte_q[0].eom;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: each strobed word is checked against the oldest predicted digest word.
	always @(posedge clk) begin
		digest_res_t want;
		if (arst_n && strobe) begin
			if (digest_q.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected digest word %h index %0d last %b",
						digest_word, word_index, last_word);
				mismatches++;
			end else begin
				want = digest_q.pop_front();
				if (digest_word !== want.word || word_index !== want.idx ||
						last_word !== want.last) begin
					if (mismatches < 10)
						$display("digest mismatch: expected %h/%0d/%b, got %h/%0d/%b",
							want.word, want.idx, want.last,
							digest_word, word_index, last_word);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: ends the run when neither side has moved an item for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
